[hdl/mbg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_pkg: shared types and constants of the maze backtracker generator
// Grid geometry, item and result payloads, controller command/status groups.
// ----------------------------------------------------------------------------
package mbg_pkg;

    // Grid limits in grid units, walls included
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;

    // Cell grid: odd coordinates are cells
    localparam int CELL_ROWS  = MAX_ROWS / 2;
    localparam int CELL_COLS  = MAX_COLS / 2;
    localparam int CELL_COUNT = CELL_ROWS * CELL_COLS;
    localparam int CR_W       = $clog2(CELL_ROWS);
    localparam int CC_W       = $clog2(CELL_COLS);
    localparam int IDX_W      = CR_W + CC_W;
    localparam int DEPTH_W    = IDX_W + 1;

    // Field widths
    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int PICK_W     = 8;

    // Configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Item actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [PICK_W-1:0]  random_pick;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               carved;
        logic               done_res;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_wr;
        logic start_wr;
        logic top_rd;
        logic rd_cur;
        logic rd_up;
        logic rd_dn;
        logic eval;
        logic pop;
        logic carve;
        logic emit_done;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic clr_last;
        logic none_open;
    } t_sts;

endpackage : mbg_pkg
`default_nettype wire

[hdl/mbg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_ctrl: sequencer of the maze backtracker generator
// Walks start items through the map clear and step items through the
// stack-top read, three visited-row reads, evaluation and carve or pop.
// ----------------------------------------------------------------------------
module mbg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_action,
    input  wire mbg_pkg::t_sts i_sts,
    output logic               busy,
    output mbg_pkg::t_cmd      o_cmd
);
    import mbg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_START,
        S_TOP,
        S_RD_CUR,
        S_RD_UP,
        S_RD_DN,
        S_EVAL,
        S_CARVE,
        S_EMPTY
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    assign busy = r_busy;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_action == ACT_START) begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_CLEAR;
                    end else if (i_sts.depth_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_TOP;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start_wr = 1'b1;
                n_state        = S_IDLE;
            end
            S_TOP: begin
                o_cmd.top_rd = 1'b1;
                n_state      = S_RD_CUR;
            end
            S_RD_CUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_RD_UP;
            end
            S_RD_UP: begin
                o_cmd.rd_up = 1'b1;
                n_state     = S_RD_DN;
            end
            S_RD_DN: begin
                o_cmd.rd_dn = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.none_open) begin
                    n_state = S_CARVE;
                end else begin
                    // drop the blocked top cell
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.depth_one ? S_EMPTY : S_TOP;
                end
            end
            S_CARVE: begin
                o_cmd.carve = 1'b1;
                n_state     = S_IDLE;
            end
            S_EMPTY: begin
                o_cmd.emit_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

endmodule : mbg_ctrl
`default_nettype wire

[hdl/mbg_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbg_dp: datapath of the maze backtracker generator
// Size registers, visited map (one word per cell row), cell stack, neighbour
// evaluation, carve logic and the result register.
// ----------------------------------------------------------------------------
module mbg_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [6:0]       i_cfg_data,
    input  wire mbg_pkg::t_item   i_item,
    input  wire mbg_pkg::t_cmd    i_cmd,
    output mbg_pkg::t_sts         o_sts,
    output logic                  o_res_valid,
    output mbg_pkg::t_result      o_res
);
    import mbg_pkg::*;

    typedef enum logic [1:0] {
        D_LEFT,
        D_UP,
        D_RIGHT,
        D_DOWN
    } t_dir;

    // Lower an out-of-grid odd start coordinate to the last odd one inside
    function automatic logic [COORD_W-1:0] fit_start(input logic [COORD_W-1:0] v,
                                                     input logic [SIZE_W-1:0]  size);
        logic [SIZE_W-1:0] odd;
        logic [SIZE_W-1:0] low;
        odd = {1'b0, v[COORD_W-1:1], 1'b1};
        low = size - SIZE_W'(2);
        if (odd >= size) begin
            return {low[COORD_W-1:1], 1'b1};
        end
        return odd[COORD_W-1:0];
    endfunction

    // Take the k-th open direction in the order left, up, right, down
    function automatic t_dir pick_dir(input logic [3:0] open, input logic [1:0] k);
        logic [2:0] seen;
        t_dir       d;
        seen = '0;
        d    = D_LEFT;
        for (int i = 0; i < 4; i++) begin
            if (open[i]) begin
                if (seen == {1'b0, k}) begin
                    d = t_dir'(i[1:0]);
                end
                seen = seen + 3'd1;
            end
        end
        return d;
    endfunction

    // Registers
    logic [SIZE_W-1:0]    r_rows_cfg, r_cols_cfg;
    t_item                r_item;
    logic [DEPTH_W-1:0]   r_depth;
    logic [CR_W-1:0]      r_clr_cnt;
    logic [CELL_COLS-1:0] r_vis_rd;
    logic [IDX_W-1:0]     r_stk_rd;
    logic [CELL_COLS-1:0] r_cur_w, r_up_w, r_dn_w;
    t_dir                 r_dir;
    t_result              r_res;
    t_result              n_res;
    logic                 r_res_vld;

    // Memories
    logic [CELL_COLS-1:0] vis_mem [CELL_ROWS];
    logic [IDX_W-1:0]     stk_mem [CELL_COUNT];

    // Effective sizes
    logic [SIZE_W-1:0] rows, cols;
    logic              grid_empty;
    assign rows = (r_rows_cfg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : r_rows_cfg;
    assign cols = (r_cols_cfg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : r_cols_cfg;
    assign grid_empty = (rows < SIZE_W'(2)) || (cols < SIZE_W'(2));

    // Start cell
    logic [COORD_W-1:0] s_row, s_col;
    assign s_row = fit_start(r_item.start_row, rows);
    assign s_col = fit_start(r_item.start_col, cols);

    // Top cell coordinates
    logic [CR_W-1:0]    cr;
    logic [CC_W-1:0]    cc;
    logic [COORD_W-1:0] r6, c6;
    logic [SIZE_W-1:0]  r7, c7;
    assign cr = r_stk_rd[IDX_W-1:CC_W];
    assign cc = r_stk_rd[CC_W-1:0];
    assign r6 = {cr, 1'b1};
    assign c6 = {cc, 1'b1};
    assign r7 = {1'b0, r6};
    assign c7 = {1'b0, c6};

    // Open neighbours: in range and not yet visited
    logic [3:0]        open;
    logic [2:0]        n_open;
    logic [10:0]       prod;
    assign open[D_LEFT]  = (cc != '0) && (r7 < rows) && ((c7 - SIZE_W'(2)) < cols)
                           && !r_cur_w[cc - CC_W'(1)];
    assign open[D_UP]    = (cr != '0) && ((r7 - SIZE_W'(2)) < rows) && (c7 < cols)
                           && !r_up_w[cc];
    assign open[D_RIGHT] = (r7 < rows) && ((c7 + SIZE_W'(2)) < cols)
                           && !r_cur_w[cc + CC_W'(1)];
    assign open[D_DOWN]  = ((r7 + SIZE_W'(2)) < rows) && (c7 < cols) && !r_vis_rd[cc];
    assign n_open = {2'b0, open[0]} + {2'b0, open[1]} + {2'b0, open[2]} + {2'b0, open[3]};
    assign prod   = {3'b0, r_item.random_pick} * {8'b0, n_open};

    // Carve target from the chosen direction
    logic [COORD_W-1:0]   nr, nc, wr, wc;
    logic [CELL_COLS-1:0] base_w, mark_w;
    always_comb begin
        nr     = r6;
        nc     = c6;
        wr     = r6;
        wc     = c6;
        base_w = r_cur_w;
        case (r_dir)
            D_LEFT: begin
                nc = c6 - COORD_W'(2);
                wc = c6 - COORD_W'(1);
            end
            D_UP: begin
                nr     = r6 - COORD_W'(2);
                wr     = r6 - COORD_W'(1);
                base_w = r_up_w;
            end
            D_RIGHT: begin
                nc = c6 + COORD_W'(2);
                wc = c6 + COORD_W'(1);
            end
            D_DOWN: begin
                nr     = r6 + COORD_W'(2);
                wr     = r6 + COORD_W'(1);
                base_w = r_dn_w;
            end
            default: begin
                nr = r6;
            end
        endcase
        mark_w = base_w | (CELL_COLS'(1) << nc[COORD_W-1:1]);
    end

    // Visited map port selection
    logic                 vis_we, vis_re;
    logic [CR_W-1:0]      vis_wa, vis_ra;
    logic [CELL_COLS-1:0] vis_wd;
    always_comb begin
        vis_we = 1'b0;
        vis_wa = r_clr_cnt;
        vis_wd = '0;
        if (i_cmd.clr_wr) begin
            vis_we = 1'b1;
        end else if (i_cmd.start_wr && !grid_empty) begin
            vis_we = 1'b1;
            vis_wa = s_row[COORD_W-1:1];
            vis_wd = CELL_COLS'(1) << s_col[COORD_W-1:1];
        end else if (i_cmd.carve) begin
            vis_we = 1'b1;
            vis_wa = nr[COORD_W-1:1];
            vis_wd = mark_w;
        end
        vis_re = i_cmd.rd_cur || i_cmd.rd_up || i_cmd.rd_dn;
        vis_ra = cr;
        if (i_cmd.rd_up) begin
            vis_ra = cr - CR_W'(1);
        end else if (i_cmd.rd_dn) begin
            vis_ra = cr + CR_W'(1);
        end
    end

    // Cell stack port selection
    logic               stk_we;
    logic [IDX_W-1:0]   stk_wa, stk_wd, stk_ra;
    logic [DEPTH_W-1:0] depth_m1;
    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign stk_ra   = depth_m1[IDX_W-1:0];
    always_comb begin
        stk_we = 1'b0;
        stk_wa = '0;
        stk_wd = {s_row[COORD_W-1:1], s_col[COORD_W-1:1]};
        if (i_cmd.start_wr && !grid_empty) begin
            stk_we = 1'b1;
        end else if (i_cmd.carve && !r_depth[IDX_W]) begin
            stk_we = 1'b1;
            stk_wa = r_depth[IDX_W-1:0];
            stk_wd = {nr[COORD_W-1:1], nc[COORD_W-1:1]};
        end
    end

    // Visited map
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_wa] <= vis_wd;
        end
        if (vis_re) begin
            r_vis_rd <= vis_mem[vis_ra];
        end
    end

    // Cell stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (i_cmd.top_rd) begin
            r_stk_rd <= stk_mem[stk_ra];
        end
    end

    // Control state: size registers, depth, clear counter, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= SIZE_W'(MAX_ROWS);
            r_cols_cfg <= SIZE_W'(MAX_COLS);
            r_depth    <= '0;
            r_clr_cnt  <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROWS) begin
                    r_rows_cfg <= i_cfg_data;
                end else begin
                    r_cols_cfg <= i_cfg_data;
                end
            end
            if (i_cmd.clr_init) begin
                r_depth   <= '0;
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + CR_W'(1);
            end else if (i_cmd.start_wr && !grid_empty) begin
                r_depth <= DEPTH_W'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end else if (i_cmd.carve && !r_depth[IDX_W]) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end
            r_res_vld <= i_cmd.start_wr || i_cmd.carve || i_cmd.emit_done;
        end
    end

    // Build the next result word
    always_comb begin
        n_res = r_res;
        if (i_cmd.start_wr) begin
            n_res = '0;
            if (grid_empty) begin
                n_res.done_res = 1'b1;
            end else begin
                n_res.cell_row = s_row;
                n_res.cell_col = s_col;
            end
        end else if (i_cmd.carve) begin
            n_res.wall_row = wr;
            n_res.wall_col = wc;
            n_res.cell_row = nr;
            n_res.cell_col = nc;
            n_res.carved   = 1'b1;
            n_res.done_res = 1'b0;
        end else if (i_cmd.emit_done) begin
            n_res          = '0;
            n_res.done_res = 1'b1;
        end
    end

    // Payload registers: item, row words, choice, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd_up) begin
            r_cur_w <= r_vis_rd;
        end
        if (i_cmd.rd_dn) begin
            r_up_w <= r_vis_rd;
        end
        if (i_cmd.eval) begin
            r_dn_w <= r_vis_rd;
            r_dir  <= pick_dir(open, prod[9:8]);
        end
        r_res <= n_res;
    end

    // Status to the controller
    assign o_sts.depth_zero = (r_depth == '0);
    assign o_sts.depth_one  = (r_depth == DEPTH_W'(1));
    assign o_sts.clr_last   = (r_clr_cnt == CR_W'(CELL_ROWS - 1));
    assign o_sts.none_open  = (open == 4'b0000);

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule : mbg_dp
`default_nettype wire

[hdl/maze_backtracker_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_generator: randomized depth-first maze carver
// Command-driven carver on a grid of odd-coordinate cells; one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_item and raise start; the item transfers at a clock edge
//   with start high and busy low. Output: one result per item, shown for a
//   single cycle with o_res_valid high; the receiver cannot stall it.
//   Configuration: i_cfg_we writes i_cfg_data into r_rows_cfg (index 0) or
//   r_cols_cfg (index 1) on that edge; user writes only while idle, unchecked.
// Work per item, from the accepting edge to the result:
//   start item: a clear of the visited map, one row word per cycle through
//     its single write port, then the start cell write.
//   step item, empty stack: the done result directly.
//   step item: each blocked cell is popped and the next entry examined. Each
//     examined stack entry costs one stack read and three visited-row reads
//     on the single read port of the visited map.
//   A new item is accepted in the cycle its predecessor's result is shown.
// Reset: sizes return to 64 x 64 and the stack empties; a step before the
// first start reports done. The visited map is cleared by each start item.
// ----------------------------------------------------------------------------
module maze_backtracker_generator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mbg_pkg::t_item    i_item,
    output logic                   o_res_valid,
    output mbg_pkg::t_result       o_res,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [6:0]        i_cfg_data
);
    import mbg_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic accept;

    assign accept = start && !busy;

    // Sequencer
    mbg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (accept),
        .i_action (i_item.action),
        .i_sts    (sts),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // Datapath
    mbg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // A transfer always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("item transfer did not raise busy");

    // Results appear only once the item has finished
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while busy");

    // Result strobe lasts one cycle
    a_res_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    // A carving step never reports done
    a_carve_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.carved && o_res.done_res))
        else $error("carved and done both set");

endmodule : maze_backtracker_generator
`default_nettype wire
